// ===== hw/rtl/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared widths, codes, types and helpers of the touch to d-pad decoder.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int CMD_W     = 2;
  localparam int TAG_W     = 8;
  localparam int TOUCH_W   = 12;
  localparam int PANEL_W   = 12;
  localparam int SCENE_W   = 11;
  localparam int COORD_W   = 16;
  localparam int BTN_IDX_W = 3;
  localparam int SAT_IN_W  = 40;

  localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOTION = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam int NUM_BUTTONS = 5;
  localparam logic [BTN_IDX_W-1:0] BTN_UP    = 3'd0;
  localparam logic [BTN_IDX_W-1:0] BTN_DOWN  = 3'd1;
  localparam logic [BTN_IDX_W-1:0] BTN_LEFT  = 3'd2;
  localparam logic [BTN_IDX_W-1:0] BTN_RIGHT = 3'd3;
  localparam logic [BTN_IDX_W-1:0] BTN_FIRE  = 3'd4;

  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 12;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCENE_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCENE_HEIGHT = 2'd3;

  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 12'd1920;
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 12'd1080;
  localparam logic [SCENE_W-1:0] SCENE_WIDTH_RST  = 11'd480;
  localparam logic [SCENE_W-1:0] SCENE_HEIGHT_RST = 11'd320;

  localparam int STICK_CENTER_DEF = 90;
  localparam int FRAC_BITS_DEF    = 4;
  localparam int EDGE_GAP         = 10;
  localparam int BUTTON_RAD       = 60;
  localparam int DEAD_DIST        = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic signed [SAT_IN_W-1:0] COORD_MAX = 40'sd32767;
  localparam logic signed [SAT_IN_W-1:0] COORD_MIN = -40'sd32768;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } op_t;

  typedef struct packed {
    logic                   idle;
    logic                   stick_owned;
    logic                   fire_owned;
    logic [NUM_BUTTONS-1:0] held;
  } status_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = 16'sh7fff;
    end else if (v < COORD_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ttd_if.sv =====
// ----------------------------------------------------------------------------
// ttd_if
// Valid/ready channels of the decoder: touch items in, button items out.
// ----------------------------------------------------------------------------
interface ttd_touch_if import ttd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [TAG_W-1:0]   pointer_tag;
  logic [TOUCH_W-1:0] touch_x;
  logic [TOUCH_W-1:0] touch_y;

  modport source (output valid, cmd, pointer_tag, touch_x, touch_y, input ready);
  modport sink   (input valid, cmd, pointer_tag, touch_x, touch_y, output ready);
endinterface

interface ttd_button_if import ttd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BTN_IDX_W-1:0] button_index;
  logic                 pressed;
  logic                 last;

  modport source (output valid, button_index, pressed, last, input ready);
  modport sink   (input valid, button_index, pressed, last, output ready);
endinterface

// ===== hw/rtl/ttd_div.sv =====
// ----------------------------------------------------------------------------
// ttd_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ttd_div import ttd_pkg::*; #(
  parameter int DW = 27
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [PANEL_W-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int STEPS = (DW + 1) / 2;
  localparam int PW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS);

  logic [PANEL_W:0]   rem;
  logic [PANEL_W:0]   rem_next;
  logic [PW-1:0]      quo;
  logic [PW-1:0]      quo_next;
  logic [PANEL_W-1:0] dvs;
  logic [CW-1:0]      cnt;
  logic               busy;

  always_comb begin
    logic [PANEL_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next[PANEL_W-1:0], quo_next[PW-1]};
      quo_next = {quo_next[PW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= PW'(dividend);
        dvs  <= divisor;
        cnt  <= CW'(STEPS - 1);
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo[DW-1:0];

endmodule

// ===== hw/rtl/ttd_front.sv =====
// ----------------------------------------------------------------------------
// ttd_front
// Accepts touch items, sorts them by command and scales the point of down
// and motion items to scene coordinates before handing an op to the queue.
// ----------------------------------------------------------------------------
module ttd_front import ttd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ttd_touch_if.sink          touch,
  input  logic [PANEL_W-1:0] panel_width,
  input  logic [PANEL_W-1:0] panel_height,
  input  logic [SCENE_W-1:0] view_width,
  input  logic [SCENE_W-1:0] view_height,
  output op_t                push_op,
  output logic               push_valid,
  input  logic               push_ready
);

  localparam int PW = TOUCH_W + SCENE_W;
  localparam int QW = PW + FRAC_BITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]         state;
  logic [CMD_W-1:0]   cmd;
  logic [TAG_W-1:0]   tag;
  logic [TOUCH_W-1:0] tx;
  logic [TOUCH_W-1:0] ty;
  logic [PW-1:0]      prod_x;
  logic [PW-1:0]      prod_y;
  logic               div_start;
  logic               done_x;
  logic               done_y;
  logic [QW-1:0]      qx;
  logic [QW-1:0]      qy;
  logic [PANEL_W-1:0] div_w;
  logic [PANEL_W-1:0] div_h;
  logic signed [COORD_W-1:0]  sx;
  logic signed [COORD_W-1:0]  sy;
  logic signed [COORD_W-1:0]  sx_c;
  logic signed [COORD_W-1:0]  sy_c;
  logic signed [SAT_IN_W-1:0] top_s;
  logic signed [SAT_IN_W-1:0] qx_s;
  logic signed [SAT_IN_W-1:0] qy_s;

  assign div_w = (panel_width == '0) ? PANEL_W'(1) : panel_width;
  assign div_h = (panel_height == '0) ? PANEL_W'(1) : panel_height;

  ttd_div #(.DW(QW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QW'(prod_x) << FRAC_BITS),
    .divisor  (div_w),
    .done     (done_x),
    .quotient (qx)
  );

  ttd_div #(.DW(QW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QW'(prod_y) << FRAC_BITS),
    .divisor  (div_h),
    .done     (done_y),
    .quotient (qy)
  );

  always_comb begin
    top_s = (SAT_IN_W'(signed'({1'b0, view_height})) - SAT_IN_W'(1)) <<< FRAC_BITS;
    qx_s  = signed'(SAT_IN_W'(qx));
    qy_s  = signed'(SAT_IN_W'(qy));
    sx_c  = sat_coord(qx_s);
    sy_c  = sat_coord(top_s - qy_s);
  end

  assign touch.ready = (state == F_IDLE);
  assign push_valid  = (state == F_PUSH);
  assign push_op     = '{cmd: cmd, tag: tag, sx: sx, sy: sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == F_MUL);
      unique case (state)
        F_IDLE: begin
          if (touch.valid) begin
            cmd <= touch.cmd;
            tag <= touch.pointer_tag;
            tx  <= touch.touch_x;
            ty  <= touch.touch_y;
            unique case (touch.cmd) inside
              CMD_DOWN, CMD_MOTION: state <= F_MUL;
              CMD_UP:               state <= F_PUSH;
              default:              state <= F_IDLE;
            endcase
          end
        end
        F_MUL: begin
          prod_x <= tx * view_width;
          prod_y <= ty * view_height;
          state  <= F_DIV;
        end
        F_DIV: begin
          if (done_x && done_y) begin
            sx    <= sx_c;
            sy    <= sy_c;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ttd_fifo.sv =====
// ----------------------------------------------------------------------------
// ttd_fifo
// Short op queue between the front and the back.
// ----------------------------------------------------------------------------
module ttd_fifo import ttd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  push_op,
  input  logic push_valid,
  output logic push_ready,
  output op_t  pop_op,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t             slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ttd_back.sv =====
// ----------------------------------------------------------------------------
// ttd_back
// Applies ops to stick and fire ownership, sorts the stick offset into a
// direction and emits one button item per changed bit.
// ----------------------------------------------------------------------------
module ttd_back import ttd_pkg::*; #(
  parameter int STICK_CENTER = STICK_CENTER_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCENE_W-1:0] view_width,
  input  op_t                pop_op,
  input  logic               pop_valid,
  output logic               pop_ready,
  ttd_button_if.source       button,
  output status_t            status
);

  localparam int FRAC_ONE   = 2 ** FRAC_BITS;
  localparam int STICK_LIM  = 2 * STICK_CENTER * FRAC_ONE;
  localparam int CENTER     = STICK_CENTER * FRAC_ONE;
  localparam int FIRE_SPAN  = 2 * (EDGE_GAP + BUTTON_RAD);
  localparam int FIRE_Y_LIM = FIRE_SPAN * FRAC_ONE;
  localparam logic [31:0] DEAD_LEN2 = 32'(DEAD_DIST * DEAD_DIST) << (2 * FRAC_BITS);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_APPLY  = 3'd1;
  localparam logic [2:0] B_SQUARE = 3'd2;
  localparam logic [2:0] B_MASK   = 3'd3;
  localparam logic [2:0] B_EMIT   = 3'd4;

  logic [2:0]             state;
  op_t                    cur;
  logic                   stick_owned;
  logic [TAG_W-1:0]       stick_owner;
  logic                   fire_owned;
  logic [TAG_W-1:0]       fire_owner;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  logic [NUM_BUTTONS-1:0] held_mask;
  logic [NUM_BUTTONS-1:0] pend;
  logic [30:0]            sq_x;
  logic [30:0]            sq_y;

  logic                   out_valid;
  logic [BTN_IDX_W-1:0]   out_index;
  logic                   out_pressed;
  logic                   out_last;

  int                     sx_i;
  int                     sy_i;
  int                     fire_x_lim;
  int                     ox_i;
  int                     oy_i;
  logic                   in_stick;
  logic                   in_fire;
  logic                   stick_hit;
  logic                   fire_hit;
  logic                   do_refresh;
  logic signed [COORD_W-1:0] place_x;
  logic signed [COORD_W-1:0] place_y;
  logic signed [31:0]     prod_x;
  logic signed [31:0]     prod_y;
  logic [31:0]            len2;
  logic [NUM_BUTTONS-1:0] next_mask;
  logic [NUM_BUTTONS-1:0] low;
  logic [NUM_BUTTONS-1:0] rest;
  logic [BTN_IDX_W-1:0]   low_idx;
  logic                   out_free;

  always_comb begin
    sx_i       = int'(cur.sx);
    sy_i       = int'(cur.sy);
    fire_x_lim = (int'(view_width) - FIRE_SPAN) * FRAC_ONE;
    in_stick   = (sx_i < STICK_LIM) && (sy_i < STICK_LIM);
    in_fire    = (sx_i > fire_x_lim) && (sy_i < FIRE_Y_LIM);
    stick_hit  = stick_owned && (cur.tag == stick_owner);
    fire_hit   = fire_owned && (cur.tag == fire_owner);
    place_x    = sat_coord(SAT_IN_W'(sx_i - CENTER));
    place_y    = sat_coord(SAT_IN_W'(sy_i - CENTER));
    unique case (cur.cmd)
      CMD_DOWN:   do_refresh = in_stick || in_fire;
      CMD_UP:     do_refresh = stick_hit || fire_hit;
      CMD_MOTION: do_refresh = stick_hit;
      default:    do_refresh = 1'b0;
    endcase
  end

  always_comb begin
    prod_x = offset_x * offset_x;
    prod_y = offset_y * offset_y;
    len2   = {1'b0, sq_x} + {1'b0, sq_y};
    ox_i   = int'(offset_x);
    oy_i   = int'(offset_y);
    next_mask = '0;
    if (len2 > DEAD_LEN2) begin
      if (oy_i > ox_i) begin
        next_mask[(oy_i < -ox_i) ? BTN_LEFT : BTN_UP] = 1'b1;
      end else begin
        next_mask[(oy_i > -ox_i) ? BTN_RIGHT : BTN_DOWN] = 1'b1;
      end
    end
    next_mask[BTN_FIRE] = fire_owned;
  end

  always_comb begin
    low     = pend & (~pend + 1'b1);
    rest    = pend & ~low;
    low_idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (low[i]) begin
        low_idx = BTN_IDX_W'(i);
      end
    end
  end

  assign out_free  = !out_valid || button.ready;
  assign pop_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      stick_owned <= 1'b0;
      stick_owner <= '0;
      fire_owned  <= 1'b0;
      fire_owner  <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      held_mask   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == B_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (button.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            cur   <= pop_op;
            state <= B_APPLY;
          end
        end
        B_APPLY: begin
          unique case (cur.cmd)
            CMD_DOWN: begin
              if (in_stick) begin
                stick_owned <= 1'b1;
                stick_owner <= cur.tag;
                offset_x    <= place_x;
                offset_y    <= place_y;
              end else if (in_fire) begin
                fire_owned <= 1'b1;
                fire_owner <= cur.tag;
              end
            end
            CMD_UP: begin
              if (stick_hit) begin
                stick_owned <= 1'b0;
                stick_owner <= '0;
                offset_x    <= '0;
                offset_y    <= '0;
              end else if (fire_hit) begin
                fire_owned <= 1'b0;
                fire_owner <= '0;
              end
            end
            CMD_MOTION: begin
              if (stick_hit) begin
                offset_x <= place_x;
                offset_y <= place_y;
              end
            end
            default: ;
          endcase
          state <= do_refresh ? B_SQUARE : B_IDLE;
        end
        B_SQUARE: begin
          sq_x  <= prod_x[30:0];
          sq_y  <= prod_y[30:0];
          state <= B_MASK;
        end
        B_MASK: begin
          held_mask <= next_mask;
          pend      <= next_mask ^ held_mask;
          state     <= ((next_mask ^ held_mask) == '0) ? B_IDLE : B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_index   <= low_idx;
            out_pressed <= |(low & held_mask);
            out_last    <= (rest == '0);
            pend        <= rest;
            if (rest == '0) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign button.valid        = out_valid;
  assign button.button_index = out_index;
  assign button.pressed      = out_pressed;
  assign button.last         = out_last;

  assign status = '{idle: (state == B_IDLE), stick_owned: stick_owned,
                    fire_owned: fire_owned, held: held_mask};

endmodule

// ===== hw/rtl/touch_to_dpad_decoder.sv =====
// ----------------------------------------------------------------------------
// touch_to_dpad_decoder
// Turns touch down/up/motion items into d-pad and fire press/release items.
// ----------------------------------------------------------------------------
// A down or motion item occupies the input side until the two-bit-per-cycle
// dividers have scaled x and y in parallel and its op is queued; an up item
// is queued unscaled and an unknown command is dropped. Ops pass through a
// 4-entry queue to the back end, which applies each op and, if it may change
// a button, emits one button item per changed bit, so input and output stall
// independently. Button items for one touch item come out in ascending button
// order (up, down, left, right, fire) with last set on the final one; an item
// that changes nothing emits nothing. The user must write configuration
// registers through cfg_wen/cfg_index/cfg_wdata only while idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_to_dpad_decoder import ttd_pkg::*; #(
  parameter int STICK_CENTER = STICK_CENTER_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [REG_DATA_W-1:0] cfg_wdata,
  ttd_touch_if.sink             touch,
  ttd_button_if.source          button
);

  logic [PANEL_W-1:0] panel_width;
  logic [PANEL_W-1:0] panel_height;
  logic [SCENE_W-1:0] view_width;
  logic [SCENE_W-1:0] view_height;

  op_t     push_op;
  logic    push_valid;
  logic    push_ready;
  op_t     pop_op;
  logic    pop_valid;
  logic    pop_ready;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
      view_width   <= SCENE_WIDTH_RST;
      view_height  <= SCENE_HEIGHT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width  <= cfg_wdata[PANEL_W-1:0];
        REG_PANEL_HEIGHT: panel_height <= cfg_wdata[PANEL_W-1:0];
        REG_SCENE_WIDTH:  view_width   <= cfg_wdata[SCENE_W-1:0];
        REG_SCENE_HEIGHT: view_height  <= cfg_wdata[SCENE_W-1:0];
        default: ;
      endcase
    end
  end

  ttd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .touch        (touch),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .view_width   (view_width),
    .view_height  (view_height),
    .push_op      (push_op),
    .push_valid   (push_valid),
    .push_ready   (push_ready)
  );

  ttd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  ttd_back #(.STICK_CENTER(STICK_CENTER), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .view_width  (view_width),
    .pop_op      (pop_op),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .button      (button),
    .status      (status)
  );

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    $onehot0(status.held[BTN_RIGHT:BTN_UP]))
    else $error("more than one direction held");

  a_fire_tracks_owner: assert property (@(posedge clk) disable iff (rst)
    status.idle |-> (status.held[BTN_FIRE] == status.fire_owned))
    else $error("fire held bit out of step with fire ownership");

  a_no_stick_no_dir: assert property (@(posedge clk) disable iff (rst)
    (status.idle && !status.stick_owned) |-> (status.held[BTN_RIGHT:BTN_UP] == '0))
    else $error("direction held without a stick owner");

  a_busy_after_scale: assert property (@(posedge clk) disable iff (rst)
    (touch.valid && touch.ready && (touch.cmd == CMD_DOWN || touch.cmd == CMD_MOTION))
      |=> !touch.ready)
    else $error("front took a new item while scaling");

endmodule

// ===== tb/sv/ttd_button_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_button_checker
// Watches the touch and button channels and the register port, keeps its own
// copy of stick/fire ownership, stick offset and held mask, and compares each
// button item with the oldest predicted change.
// ----------------------------------------------------------------------------
module ttd_button_checker import ttd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [REG_DATA_W-1:0] cfg_wdata,
  ttd_touch_if                  touch,
  ttd_button_if                 button,
  output int                    errors,
  output int                    pending
);

  localparam longint F         = longint'(1) << FRAC_BITS_DEF;
  localparam longint STICK_LIM = 2 * STICK_CENTER_DEF * F;
  localparam longint FIRE_SPAN = 2 * (EDGE_GAP + BUTTON_RAD);
  localparam longint DEAD_LEN2 = DEAD_DIST * DEAD_DIST * F * F;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] idx;
    logic                 pressed;
    logic                 last;
  } change_t;

  change_t changes_q[$];

  logic [PANEL_W-1:0]        panel_w, panel_h;
  logic [SCENE_W-1:0]        scene_w, scene_h;
  logic                      stick_on, fire_on;
  logic [TAG_W-1:0]          stick_tag, fire_tag;
  logic signed [COORD_W-1:0] off_x, off_y;
  logic [NUM_BUTTONS-1:0]    held;

  function automatic logic signed [COORD_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic void to_scene(input logic [TOUCH_W-1:0] tx, input logic [TOUCH_W-1:0] ty,
                                   output longint sx, output longint sy);
    longint pw, ph, sh;
    pw = (panel_w == '0) ? 1 : longint'(panel_w);
    ph = (panel_h == '0) ? 1 : longint'(panel_h);
    sh = longint'(scene_h);
    sx = clamp16(longint'(tx) * longint'(scene_w) * F / pw);
    sy = clamp16((sh - 1) * F - longint'(ty) * sh * F / ph);
  endfunction

  function automatic void place_stick(longint sx, longint sy);
    off_x = clamp16(sx - STICK_CENTER_DEF * F);
    off_y = clamp16(sy - STICK_CENTER_DEF * F);
  endfunction

  // Queue one item per changed button, lowest index first.
  function automatic void predict_changes();
    longint x, y;
    logic [NUM_BUTTONS-1:0] next, diff;
    change_t c;
    x = off_x;
    y = off_y;
    next = '0;
    if (x * x + y * y > DEAD_LEN2) begin
      if (y > x) next[(y < -x) ? BTN_LEFT : BTN_UP] = 1'b1;
      else next[(y > -x) ? BTN_RIGHT : BTN_DOWN] = 1'b1;
    end
    if (fire_on) next[BTN_FIRE] = 1'b1;
    diff = next ^ held;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (diff[i]) begin
        c.idx = BTN_IDX_W'(i);
        c.pressed = next[i];
        c.last = ((diff >> (i + 1)) == '0);
        changes_q.push_back(c);
      end
    end
    held = next;
  endfunction

  always @(posedge clk) begin : watch
    change_t got, want;
    longint sx, sy;
    if (rst) begin
      panel_w = PANEL_WIDTH_RST;
      panel_h = PANEL_HEIGHT_RST;
      scene_w = SCENE_WIDTH_RST;
      scene_h = SCENE_HEIGHT_RST;
      stick_on = 1'b0;
      fire_on = 1'b0;
      stick_tag = '0;
      fire_tag = '0;
      off_x = '0;
      off_y = '0;
      held = '0;
      changes_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  panel_w = cfg_wdata[PANEL_W-1:0];
          REG_PANEL_HEIGHT: panel_h = cfg_wdata[PANEL_W-1:0];
          REG_SCENE_WIDTH:  scene_w = cfg_wdata[SCENE_W-1:0];
          REG_SCENE_HEIGHT: scene_h = cfg_wdata[SCENE_W-1:0];
          default: ;
        endcase
      end
      if (button.valid && button.ready) begin
        got.idx = button.button_index;
        got.pressed = button.pressed;
        got.last = button.last;
        if (changes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected button item: idx %0d pressed %0b last %0b",
                   $time, got.idx, got.pressed, got.last);
        end else begin
          want = changes_q.pop_front();
          if (want != got) begin
            errors++;
            $display({"%0t: button item expected idx %0d pressed %0b last %0b,",
                      " got idx %0d pressed %0b last %0b"},
                     $time, want.idx, want.pressed, want.last,
                     got.idx, got.pressed, got.last);
          end
        end
      end
      if (touch.valid && touch.ready) begin
        case (touch.cmd)
          CMD_DOWN: begin
            to_scene(touch.touch_x, touch.touch_y, sx, sy);
            if (sx < STICK_LIM && sy < STICK_LIM) begin
              stick_on = 1'b1;
              stick_tag = touch.pointer_tag;
              place_stick(sx, sy);
              predict_changes();
            end else if (sx > (longint'(scene_w) - FIRE_SPAN) * F && sy < FIRE_SPAN * F) begin
              fire_on = 1'b1;
              fire_tag = touch.pointer_tag;
              predict_changes();
            end
          end
          CMD_UP: begin
            if (stick_on && touch.pointer_tag == stick_tag) begin
              stick_on = 1'b0;
              stick_tag = '0;
              off_x = '0;
              off_y = '0;
              predict_changes();
            end else if (fire_on && touch.pointer_tag == fire_tag) begin
              fire_on = 1'b0;
              fire_tag = '0;
              predict_changes();
            end
          end
          CMD_MOTION: begin
            if (stick_on && touch.pointer_tag == stick_tag) begin
              to_scene(touch.touch_x, touch.touch_y, sx, sy);
              place_stick(sx, sy);
              predict_changes();
            end
          end
          default: ;
        endcase
      end
    end
    pending = changes_q.size();
  end

endmodule

// ===== tb/sv/tb_touch_to_dpad_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_to_dpad_decoder
// Drives directed and random touch items through several register settings
// and idle/stall patterns, including a long output hold-off; the checker
// beside the block predicts and compares every button item.
// ----------------------------------------------------------------------------
module tb_touch_to_dpad_decoder;
  import ttd_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [REG_DATA_W-1:0] cfg_wdata;

  int send_idle_pct, recv_stall_pct;
  int hold_requests, holds_served;
  int chk_errors, chk_pending;
  int pw_cur, ph_cur, sw_cur, sh_cur;

  ttd_touch_if  touch_ch();
  ttd_button_if button_ch();

  touch_to_dpad_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .touch     (touch_ch),
    .button    (button_ch)
  );

  ttd_button_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .touch     (touch_ch),
    .button    (button_ch),
    .errors    (chk_errors),
    .pending   (chk_pending)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  initial begin
    #3000000;
    $display("[touch_to_dpad_decoder] ERROR");
    $finish;
  end

  // Button side: random stalls, plus a long hold-off on request.
  initial begin
    holds_served = 0;
    button_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        button_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      button_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scene pixel to raw panel coordinate, clamped to the field range.
  function automatic int to_panel(int p, int scene, int panel);
    int v;
    v = p * ((panel == 0) ? 1 : panel) / ((scene == 0) ? 1 : scene);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic send_touch(logic [CMD_W-1:0] cmd, int tag, int x, int y);
    while ($urandom_range(99) < send_idle_pct) begin
      touch_ch.valid = 1'b0;
      @(negedge clk);
    end
    touch_ch.valid = 1'b1;
    touch_ch.cmd = cmd;
    touch_ch.pointer_tag = TAG_W'(tag);
    touch_ch.touch_x = TOUCH_W'(x);
    touch_ch.touch_y = TOUCH_W'(y);
    do @(posedge clk); while (!touch_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_at(logic [CMD_W-1:0] cmd, int tag, int px, int py);
    send_touch(cmd, tag, to_panel(px, sw_cur, pw_cur),
               to_panel(sh_cur - 1 - py, sh_cur, ph_cur));
  endtask

  // Mostly owner-driven sequences on a few tags, some noise.
  task automatic send_random();
    int r, tag;
    r = $urandom_range(99);
    tag = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
    if (r < 10) send_touch(CMD_W'($urandom_range(3)), tag,
                           $urandom_range(4095), $urandom_range(4095));
    else if (r < 35) send_at(CMD_DOWN, tag, $urandom_range(179), $urandom_range(179));
    else if (r < 50) send_at(CMD_DOWN, tag, sw_cur - 1 - $urandom_range(138), $urandom_range(139));
    else if (r < 85) send_at(CMD_MOTION, tag, $urandom_range(200), $urandom_range(200));
    else send_touch(CMD_UP, tag, $urandom_range(4095), $urandom_range(4095));
  endtask

  task automatic drain();
    touch_ch.valid = 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int val);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_wdata = REG_DATA_W'(val);
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic set_config(int pw, int ph, int sw, int sh);
    drain();
    write_reg(REG_PANEL_WIDTH, pw);
    write_reg(REG_PANEL_HEIGHT, ph);
    write_reg(REG_SCENE_WIDTH, sw);
    write_reg(REG_SCENE_HEIGHT, sh);
    pw_cur = pw;
    ph_cur = ph;
    sw_cur = sw;
    sh_cur = sh;
  endtask

  task automatic run_phase(int pw, int ph, int sw, int sh, int idle, int stall, int n);
    set_config(pw, ph, sw, sh);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_random();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    touch_ch.valid = 1'b0;
    touch_ch.cmd = CMD_DOWN;
    touch_ch.pointer_tag = '0;
    touch_ch.touch_x = '0;
    touch_ch.touch_y = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    pw_cur = PANEL_WIDTH_RST;
    ph_cur = PANEL_HEIGHT_RST;
    sw_cur = SCENE_WIDTH_RST;
    sh_cur = SCENE_HEIGHT_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed, reset geometry: center of the stick is raw (360, 773).
    send_touch(CMD_NONE, 255, 4095, 4095);
    send_touch(CMD_UP, 7, 0, 0);
    send_touch(CMD_MOTION, 7, 600, 773);
    send_touch(CMD_DOWN, 1, 360, 773);
    send_touch(CMD_MOTION, 1, 600, 773);
    send_touch(CMD_MOTION, 1, 120, 773);
    send_touch(CMD_MOTION, 1, 360, 500);
    send_touch(CMD_MOTION, 1, 360, 1000);
    send_touch(CMD_MOTION, 1, 360, 1000);
    send_touch(CMD_DOWN, 2, 1800, 900);
    send_touch(CMD_DOWN, 3, 1900, 1000);
    send_touch(CMD_UP, 2, 0, 0);
    send_touch(CMD_DOWN, 3, 600, 773);
    send_touch(CMD_UP, 3, 0, 0);
    send_touch(CMD_UP, 3, 0, 0);
    send_touch(CMD_DOWN, 0, 0, 4095);
    send_touch(CMD_MOTION, 0, 4095, 0);
    send_touch(CMD_MOTION, 0, 0, 0);
    send_touch(CMD_MOTION, 0, 4095, 4095);
    send_touch(CMD_UP, 1, 0, 0);
    send_touch(CMD_UP, 0, 0, 0);
    send_touch(CMD_DOWN, 255, 4095, 4095);
    send_touch(CMD_DOWN, 0, 0, 4095);
    send_touch(CMD_UP, 255, 0, 0);
    send_touch(CMD_UP, 0, 0, 0);

    run_phase(4095, 4095, 2047, 2047, 86, 0, 25);
    run_phase(1, 1, 1, 1, 0, 86, 15);
    run_phase(0, 0, 480, 320, 9, 9, 15);

    // Hold the button side while stick flips keep coming, to back up the input.
    set_config(1920, 1080, 480, 320);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_at(CMD_DOWN, 0, 150, 90);
    repeat (12) begin
      send_at(CMD_MOTION, 0, 30, 90);
      send_at(CMD_MOTION, 0, 150, 90);
    end
    repeat (15) send_random();

    run_phase(800, 600, 640, 480, 9, 9, 15);
    drain();

    if (chk_errors == 0) begin
      $display("[touch_to_dpad_decoder] OK");
    end else begin
      $display("[touch_to_dpad_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== touch_to_dpad_decoder.f =====
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_if.sv
hw/rtl/ttd_div.sv
hw/rtl/ttd_front.sv
hw/rtl/ttd_fifo.sv
hw/rtl/ttd_back.sv
hw/rtl/touch_to_dpad_decoder.sv
tb/sv/ttd_button_checker.sv
tb/sv/tb_touch_to_dpad_decoder.sv
